// ----- hw/rtl/swa_pkg.sv -----
// Shared constants for the sliding window average block.
package swa_pkg;

   localparam int SAMPLE_W = 32;
   localparam int WINDOW_LENGTH_DEFAULT = 16;

endpackage

// ----- hw/rtl/swa_req_if.sv -----
// Sample channel: valid/ready handshake carrying one sample word.
interface swa_req_if;
   import swa_pkg::*;

   logic valid;
   logic ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

// ----- hw/rtl/swa_rsp_if.sv -----
// Result channel: valid/ready handshake carrying the average and the full flag.
interface swa_rsp_if;
   import swa_pkg::*;

   logic valid;
   logic ready;
   logic signed [SAMPLE_W-1:0] average;
   logic window_full;

   modport source (output valid, output average, output window_full, input ready);
   modport sink (input valid, input average, input window_full, output ready);
endinterface

// ----- hw/rtl/swa_ring.sv -----
// Sample ring memory with read-modify-write of the running sum, position and full flag.
module swa_ring #(
   parameter int WINDOW_LENGTH = swa_pkg::WINDOW_LENGTH_DEFAULT,
   parameter int SUM_W = swa_pkg::SAMPLE_W + $clog2(WINDOW_LENGTH),
   parameter int DIV_W = $clog2(WINDOW_LENGTH + 1)
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [swa_pkg::SAMPLE_W-1:0] sample,
   output logic done,
   output logic signed [SUM_W-1:0] sum,
   output logic [DIV_W-1:0] divisor,
   output logic filled
);
   import swa_pkg::*;

   localparam int POS_W = $clog2(WINDOW_LENGTH);

   logic signed [SAMPLE_W-1:0] mem [WINDOW_LENGTH];
   logic signed [SAMPLE_W-1:0] rd_data_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic filled_ff, filled_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic step_ff, done_ff;
   logic signed [SAMPLE_W-1:0] old_sample;
   logic wrap;

   // Entries at or past the write position hold data only after the first wrap.
   assign old_sample = filled_ff ? rd_data_ff : '0;
   assign wrap = (pos_ff == POS_W'(WINDOW_LENGTH - 1));

   always_comb begin
      sum_in = sum_ff - SUM_W'(old_sample) + SUM_W'(sample_ff);
      pos_in = wrap ? '0 : pos_ff + POS_W'(1);
      filled_in = filled_ff | wrap;
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rd_data_ff <= mem[pos_ff];
         sample_ff <= sample;
      end
      if (step_ff) begin
         mem[pos_ff] <= sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         filled_ff <= 1'b0;
         sum_ff <= '0;
         step_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= start;
         done_ff <= step_ff;
         if (step_ff) begin
            pos_ff <= pos_in;
            filled_ff <= filled_in;
            sum_ff <= sum_in;
         end
      end
   end

   assign done = done_ff;
   assign sum = sum_ff;
   assign filled = filled_ff;
   assign divisor = filled_ff ? DIV_W'(WINDOW_LENGTH) : DIV_W'(pos_ff);
endmodule

// ----- hw/rtl/swa_div.sv -----
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
module swa_div #(
   parameter int SUM_W = 36,
   parameter int DIV_W = 5
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [SUM_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic done,
   output logic signed [swa_pkg::SAMPLE_W-1:0] quotient
);
   import swa_pkg::*;

   localparam int CNT_W = $clog2(SUM_W + 1);

   logic busy_ff;
   logic done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic neg_ff;
   logic [SUM_W-1:0] q_ff;
   logic [DIV_W-1:0] rem_ff;
   logic [DIV_W-1:0] dvs_ff;
   logic [DIV_W:0] trial;
   logic [DIV_W:0] diff;
   logic fits;
   logic [SAMPLE_W-1:0] q_mag;

   always_comb begin
      trial = {rem_ff, q_ff[SUM_W-1]};
      diff = trial - {1'b0, dvs_ff};
      fits = (trial >= {1'b0, dvs_ff});
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[SUM_W-1];
         q_ff <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         q_ff <= {q_ff[SUM_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= CNT_W'(SUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign q_mag = q_ff[SAMPLE_W-1:0];
   assign quotient = neg_ff ? signed'(-q_mag) : signed'(q_mag);
   assign done = done_ff;
endmodule

// ----- hw/rtl/sliding_window_average_int_top.sv -----
// Top level of the sliding window average: handshakes, sequencing and result register.
//
//   channel   dir  handshake          word
//   req_chan  in   valid/ready        sample (signed 32)
//   rsp_chan  out  valid/ready        average (signed 32), window_full
//
// Each accepted sample passes through the ring update and then the bit-serial
// divider before its result is loaded; the block takes no new sample until then.
// A new sample is taken once the previous result has moved into the output register.
// Reset is synchronous; the ring contents need no clearing since the full flag
// and write position mark which entries hold data.
// A stalled result holds the divider output until the output register frees up.
module sliding_window_average_int_top #(
   parameter int WINDOW_LENGTH = swa_pkg::WINDOW_LENGTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   swa_req_if.sink req_chan,
   swa_rsp_if.source rsp_chan
);
   import swa_pkg::*;

   localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_LENGTH);
   localparam int DIV_W = $clog2(WINDOW_LENGTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WORK = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] average_ff;
   logic full_ff;

   logic req_take;
   logic ring_done;
   logic signed [SUM_W-1:0] ring_sum;
   logic [DIV_W-1:0] ring_divisor;
   logic ring_filled;
   logic div_done;
   logic signed [SAMPLE_W-1:0] div_quotient;
   logic rsp_free;
   logic load;

   swa_ring #(
      .WINDOW_LENGTH(WINDOW_LENGTH),
      .SUM_W(SUM_W),
      .DIV_W(DIV_W)
   ) u_ring (
      .clock(clock),
      .reset(reset),
      .start(req_take),
      .sample(req_chan.sample),
      .done(ring_done),
      .sum(ring_sum),
      .divisor(ring_divisor),
      .filled(ring_filled)
   );

   swa_div #(
      .SUM_W(SUM_W),
      .DIV_W(DIV_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(ring_done),
      .dividend(ring_sum),
      .divisor(ring_divisor),
      .done(div_done),
      .quotient(div_quotient)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in = state_ff;
      load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_WORK;
            end
         end
         ST_WORK: begin
            if (div_done) begin
               if (rsp_free) begin
                  load = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (rsp_free) begin
               load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = load || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         average_ff <= div_quotient;
         full_ff <= ring_filled;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.average = average_ff;
   assign rsp_chan.window_full = full_ff;

   a_ring_done_in_work: assert property (@(posedge clock) disable iff (reset)
      ring_done |-> (state_ff == ST_WORK))
      else $error("ring update finished outside of the work state");

   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_WORK))
      else $error("accepted sample did not start work");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      ring_done |-> (ring_divisor != '0))
      else $error("divider started with a zero divisor");

   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_WORK || $past(state_ff) == ST_HOLD))
      else $error("result word appeared without a finished division");
endmodule

// ----- sim/swa_average_checker.sv -----
// Checker for the sliding window average: predicts each average and compares it.
`timescale 1ns / 100ps

module swa_average_checker #(
   parameter int WINDOW_LENGTH = swa_pkg::WINDOW_LENGTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   swa_req_if   req_mon,
   swa_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   pending_count,
   output int   averages_checked,
   output int   full_averages
);
   import swa_pkg::*;

   localparam int POS_W = $clog2(WINDOW_LENGTH);
   localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_LENGTH);
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] average;
      logic                       window_full;
   } window_result_type;

   logic signed [SAMPLE_W-1:0] window_ring [WINDOW_LENGTH];
   logic [POS_W-1:0]           ring_pos;
   logic signed [SUM_W-1:0]    window_sum;
   logic                       ring_full;
   window_result_type          averages_due [$];

   // The running sum always equals the sum of the ring, and during warm-up the
   // divisor is the number of samples taken so far.
   function automatic window_result_type advance_window(
      input logic signed [SAMPLE_W-1:0] sample_in);
      logic signed [SUM_W-1:0] divisor;
      logic signed [SUM_W-1:0] quotient;
      window_result_type       result;
      window_sum = window_sum - window_ring[ring_pos] + sample_in;
      window_ring[ring_pos] = sample_in;
      if (ring_pos == POS_W'(WINDOW_LENGTH - 1)) begin
         ring_pos = '0;
         ring_full = 1'b1;
      end else begin
         ring_pos = ring_pos + 1'b1;
      end
      divisor = ring_full ? SUM_W'(WINDOW_LENGTH) : SUM_W'(ring_pos);
      quotient = window_sum / divisor;
      result.average = quotient[SAMPLE_W-1:0];
      result.window_full = ring_full;
      return result;
   endfunction

   initial begin
      mismatch_count = 0;
      averages_checked = 0;
      full_averages = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      window_result_type due;
      if (reset) begin
         for (int i = 0; i < WINDOW_LENGTH; i++) begin
            window_ring[i] = '0;
         end
         ring_pos = '0;
         window_sum = '0;
         ring_full = 1'b0;
         averages_due.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (averages_due.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT) begin
                  $display("%0t: result word with no sample pending: average %0d full %0b",
                           $realtime, rsp_mon.average, rsp_mon.window_full);
               end
               mismatch_count++;
            end else begin
               due = averages_due.pop_front();
               if (rsp_mon.average !== due.average ||
                   rsp_mon.window_full !== due.window_full) begin
                  if (mismatch_count < REPORT_LIMIT) begin
                     $display({"%0t: result word %0d: expected average %0d full %0b, ",
                               "got %0d full %0b"},
                              $realtime, averages_checked, $signed(due.average),
                              due.window_full, rsp_mon.average, rsp_mon.window_full);
                  end
                  mismatch_count++;
               end
               if (due.window_full) begin
                  full_averages++;
               end
               averages_checked++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            averages_due.push_back(advance_window(req_mon.sample));
         end
      end
      pending_count <= averages_due.size();
   end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the sliding window average: clock, reset, sample stimulus and verdict.
`timescale 1ns / 100ps

module tb;
   import swa_pkg::*;

   localparam int RANDOM_SAMPLES  = 1000;
   localparam int LONG_HOLD       = 300;
   localparam int HOLD_AT         = 300;
   localparam int DRAIN_AT        = 600;
   localparam int SETTLE_CYCLES   = 100;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int DIRECTED_COUNT  = 20;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

   // The first sixteen words cover the whole warm-up, with negative sums that
   // must truncate toward zero; the sixteenth fills the window.
   localparam logic signed [SAMPLE_W-1:0] DIRECTED_SAMPLES [DIRECTED_COUNT] = '{
      SAMPLE_MAX, SAMPLE_MIN, -32'sd1, -32'sd2, 32'sd1, 32'sd3, -32'sd5, 32'sd7,
      SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, 32'sd0, -32'sd9, 32'sd11, -32'sd13,
      32'sh5555_5555, 32'shAAAA_AAAA, -32'sd3, 32'sd4, SAMPLE_MIN
   };

   typedef enum int {
      MIX_FULL_RANGE,
      MIX_SMALL,
      MIX_EXTREME_RUN,
      MIX_NEAR_EXTREME,
      MIX_SCALED
   } sample_mix_type;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   pending_count;
   int   averages_checked;
   int   full_averages;
   int   samples_sent;
   int   idle_cycles;
   bit   long_hold_request;

   swa_req_if req_chan ();
   swa_rsp_if rsp_chan ();

   sliding_window_average_int_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   swa_average_checker average_check (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count),
      .averages_checked (averages_checked),
      .full_averages    (full_averages)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic offer_sample(input logic signed [SAMPLE_W-1:0] word, input int gap);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.sample <= word;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      samples_sent++;
   endtask

   function automatic logic signed [SAMPLE_W-1:0] draw_sample(
      input sample_mix_type mix,
      input logic signed [SAMPLE_W-1:0] level);
      logic signed [SAMPLE_W-1:0] word;
      case (mix)
         MIX_SMALL: begin
            word = int'($urandom_range(0, 40)) - 20;
         end
         MIX_EXTREME_RUN: begin
            word = level;
         end
         MIX_NEAR_EXTREME: begin
            if ($urandom_range(0, 1) == 1) begin
               word = SAMPLE_MAX - int'($urandom_range(0, 15));
            end else begin
               word = SAMPLE_MIN + int'($urandom_range(0, 15));
            end
         end
         MIX_SCALED: begin
            word = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 1) == 1) begin
               word = -word;
            end
         end
         default: begin
            word = $urandom;
         end
      endcase
      return word;
   endfunction

   initial begin
      int                         random_sent;
      int                         run_left;
      bit                         sender_quiet;
      sample_mix_type             mix;
      logic signed [SAMPLE_W-1:0] level;
      int                         gap;
      random_sent = 0;
      run_left = 0;
      sender_quiet = 1'b0;
      mix = MIX_FULL_RANGE;
      level = SAMPLE_MAX;
      samples_sent = 0;
      long_hold_request = 1'b0;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.sample <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_SAMPLES[i]) begin
         offer_sample(DIRECTED_SAMPLES[i], $urandom_range(0, 10));
      end

      while (random_sent < RANDOM_SAMPLES) begin
         if (run_left == 0) begin
            mix = sample_mix_type'($urandom_range(0, 4));
            run_left = (mix == MIX_EXTREME_RUN) ? $urandom_range(16, 40) : $urandom_range(8, 40);
            level = ($urandom_range(0, 1) == 1) ? SAMPLE_MAX : SAMPLE_MIN;
            sender_quiet = ($urandom_range(0, 3) == 0);
         end
         if (random_sent == HOLD_AT) begin
            long_hold_request = 1'b1;
         end
         if (random_sent == DRAIN_AT) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
            while (pending_count != 0) @(posedge clock);
         end
         gap = sender_quiet ? 0 : $urandom_range(0, 10);
         offer_sample(draw_sample(mix, level), gap);
         run_left--;
         random_sent++;
      end
      req_chan.valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display({"Run covered %0d samples (%0d directed) and %0d averages, ",
                "%0d of them over a full window,"},
               samples_sent, DIRECTED_COUNT, averages_checked, full_averages);
      $display("with random stalls on both sides, one long output stall and one drain pause.");
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      int  stall;
      int  words_taken;
      bit  receiver_quiet;
      words_taken = 0;
      receiver_quiet = 1'b0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            stall = LONG_HOLD;
         end else if (receiver_quiet) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, 10);
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         words_taken++;
         if (words_taken % 40 == 0) begin
            receiver_quiet = ($urandom_range(0, 3) == 0);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("Watchdog: no word moved for %0d cycles, %0d averages still pending",
               WATCHDOG_LIMIT, pending_count);
      $display("Mismatches found");
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/swa_pkg.sv
hw/rtl/swa_req_if.sv
hw/rtl/swa_rsp_if.sv
hw/rtl/swa_ring.sv
hw/rtl/swa_div.sv
hw/rtl/sliding_window_average_int_top.sv
sim/swa_average_checker.sv
sim/tb.sv
